>>> design/prq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and codes for the process ready queue: slot layout, cell
// control group, op codes and result codes.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int NameW  = 64;
  localparam int IdW    = 16;
  localparam int TimeW  = 16;
  localparam int QuantW = 10;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_RUN  = 2'd1,
    OP_REM  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RC_OK       = 2'd0,
    RC_EMPTY    = 2'd1,
    RC_FULL     = 2'd2,
    RC_NOTFOUND = 2'd3
  } rcode_t;

  typedef struct packed {
    logic [IdW-1:0]          id;
    logic [NameW-1:0]        name;
    logic                    rdy;
    logic signed [TimeW-1:0] tleft;
  } slot_t;

  typedef struct packed {
    logic load;
    logic run;
    logic shift_all;
    logic shift_hit;
    logic seen_clr;
    logic seen_step;
  } ctl_t;

endpackage

>>> design/process_ready_queue_quantum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_ready_queue_quantum
// Ordered ready queue of process entries with a time slice per run, built
// as a row of slot cells that shift toward the head.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Enqueue, ops with no
// effect and ops refused on an empty queue pass the execute state and
// register their result in the report state; a run passes the run check
// too, and a remove by name the search state, where the match flag travels
// one cell per cycle down the row of QUEUE_DEPTH cells, and then the shift
// that closes the gap. A new item is accepted the cycle after the result is
// registered, even while it still waits on out_ready. While one result
// waits on out_ready, the next one holds in its report state until the
// first leaves. The quantum register resets to 10.
// ----------------------------------------------------------------------------
module process_ready_queue_quantum #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NAME_BYTES  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [prq_pkg::QuantW-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [prq_pkg::IdW-1:0]           in_proc_id,
  input  logic [prq_pkg::NameW-1:0]         in_proc_name,
  input  logic                              in_ready_flag,
  input  logic signed [prq_pkg::TimeW-1:0]  in_time_left,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_result_code,
  output logic                              out_head_finished,
  output logic [prq_pkg::IdW-1:0]           out_head_id,
  output logic signed [prq_pkg::TimeW-1:0]  out_head_time,
  output logic                              out_head_ready,
  output logic [4:0]                        out_entry_count
);
  import prq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN_CHK,
    ST_SEARCH,
    ST_SHIFT,
    ST_REPORT
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [IW-1:0]        step_r;
  logic [QuantW-1:0]    quantum_r;
  op_t                  op_r;
  slot_t                item_r;
  rcode_t               code_r;
  logic                 fin_r;
  ctl_t                 ctl;

  logic                 out_valid_r;
  rcode_t               out_code_r;
  logic                 out_fin_r;
  logic [IdW-1:0]       out_id_r;
  logic signed [TimeW-1:0] out_time_r;
  logic                 out_rdy_r;
  logic [4:0]           out_cnt_r;

  logic [NameW-1:0]     cut_name;
  logic [CW+4:0]        cnt_ext;
  slot_t                slot_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] seen_w;
  logic                 head_done;

  // keep name bytes up to the first zero byte
  always_comb begin
    logic keep;
    keep     = 1'b1;
    cut_name = '0;
    for (int b = 0; b < 8; b++) begin
      if (keep && (b < NAME_BYTES) && (in_proc_name[8*b +: 8] != 8'd0)) begin
        cut_name[8*b +: 8] = in_proc_name[8*b +: 8];
      end else begin
        keep = 1'b0;
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign cnt_ext   = {5'd0, count_r};
  assign head_done = slot_w[0].tleft[TimeW-1] || (slot_w[0].tleft == '0);

  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.seen_clr = in_valid;
      end
      ST_EXEC: begin
        ctl.load = (op_r == OP_ENQ) && (count_r != CW'(QUEUE_DEPTH));
        ctl.run  = (op_r == OP_RUN) && (count_r != '0);
      end
      ST_RUN_CHK: begin
        ctl.shift_all = head_done;
      end
      ST_SEARCH: begin
        ctl.seen_step = 1'b1;
      end
      ST_SHIFT: begin
        ctl.shift_hit = seen_w[QUEUE_DEPTH-1];
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t nb_slot;
    logic  nb_seen;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_slot = slot_w[i];
    end else begin : g_mid
      assign nb_slot = slot_w[i+1];
    end
    if (i == 0) begin : g_first
      assign nb_seen = 1'b0;
    end else begin : g_rest
      assign nb_seen = seen_w[i-1];
    end
    prq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .tail_sel  (count_r == CW'(i)),
      .is_head   (i == 0),
      .occupied  (CW'(i) < count_r),
      .quantum   (quantum_r),
      .key       (item_r.name),
      .load_slot (item_r),
      .next_slot (nb_slot),
      .seen_in   (nb_seen),
      .slot      (slot_w[i]),
      .seen_out  (seen_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QuantW'(10);
    end else if (cfg_valid && cfg_ready) begin
      quantum_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      op_r        <= OP_NONE;
      code_r      <= RC_OK;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_code_r  <= RC_OK;
      out_fin_r   <= 1'b0;
      out_id_r    <= '0;
      out_time_r  <= '0;
      out_rdy_r   <= 1'b0;
      out_cnt_r   <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_REPORT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r         <= op_t'(in_op);
            item_r.id    <= in_proc_id;
            item_r.name  <= cut_name;
            item_r.rdy   <= in_ready_flag;
            item_r.tleft <= in_time_left;
            code_r       <= RC_OK;
            fin_r        <= 1'b0;
            step_r       <= '0;
            state_r      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= ST_REPORT;
          case (op_r)
            OP_ENQ: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                code_r <= RC_FULL;
              end else begin
                count_r <= count_r + 1'b1;
              end
            end
            OP_RUN: begin
              if (count_r == '0) begin
                code_r <= RC_EMPTY;
              end else begin
                state_r <= ST_RUN_CHK;
              end
            end
            OP_REM: begin
              if (count_r == '0) begin
                code_r <= RC_EMPTY;
              end else begin
                state_r <= ST_SEARCH;
              end
            end
            default: begin
              code_r <= RC_OK;
            end
          endcase
        end
        ST_RUN_CHK: begin
          if (head_done) begin
            count_r <= count_r - 1'b1;
            fin_r   <= 1'b1;
          end
          state_r <= ST_REPORT;
        end
        ST_SEARCH: begin
          step_r <= step_r + 1'b1;
          if (step_r == IW'(QUEUE_DEPTH - 1)) begin
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (seen_w[QUEUE_DEPTH-1]) begin
            count_r <= count_r - 1'b1;
          end else begin
            code_r <= RC_NOTFOUND;
          end
          state_r <= ST_REPORT;
        end
        ST_REPORT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_code_r  <= code_r;
            out_fin_r   <= fin_r;
            out_cnt_r   <= cnt_ext[4:0];
            if (count_r != '0) begin
              out_id_r   <= slot_w[0].id;
              out_time_r <= slot_w[0].tleft;
              out_rdy_r  <= slot_w[0].rdy;
            end else begin
              out_id_r   <= '0;
              out_time_r <= '0;
              out_rdy_r  <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_code   = out_code_r;
  assign out_head_finished = out_fin_r;
  assign out_head_id       = out_id_r;
  assign out_head_time     = out_time_r;
  assign out_head_ready    = out_rdy_r;
  assign out_entry_count   = out_cnt_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted item not executed");

  a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> out_code_r == RC_OK)
    else $error("finished head with error code");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
         count_r == $past(count_r) - 1'b1))
    else $error("count moved by more than one");
`endif

endmodule

>>> design/prq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_cell
// One queue slot: holds an entry, takes the neighbor's entry on a shift,
// runs a time slice when it is the head, and passes the match flag along.
// ----------------------------------------------------------------------------
module prq_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prq_pkg::ctl_t                 ctl,
  input  logic                          tail_sel,
  input  logic                          is_head,
  input  logic                          occupied,
  input  logic [prq_pkg::QuantW-1:0]    quantum,
  input  logic [prq_pkg::NameW-1:0]     key,
  input  prq_pkg::slot_t                load_slot,
  input  prq_pkg::slot_t                next_slot,
  input  logic                          seen_in,
  output prq_pkg::slot_t                slot,
  output logic                          seen_out
);
  import prq_pkg::*;

  slot_t                   slot_r, slot_nxt;
  logic                    seen_r, seen_nxt;
  logic                    match;
  logic signed [TimeW:0]   diff;
  logic signed [TimeW-1:0] sat_time;

  assign match    = occupied && (slot_r.name == key);
  assign seen_out = seen_r | match;
  assign slot     = slot_r;

  assign diff     = {slot_r.tleft[TimeW-1], slot_r.tleft} -
                    $signed({{(TimeW+1-QuantW){1'b0}}, quantum});
  assign sat_time = (diff[TimeW] != diff[TimeW-1]) ?
                    {1'b1, {(TimeW-1){1'b0}}} : diff[TimeW-1:0];

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.load && tail_sel) begin
      slot_nxt = load_slot;
    end else if (ctl.shift_all || (ctl.shift_hit && seen_out)) begin
      slot_nxt = next_slot;
    end else if (ctl.run && is_head) begin
      slot_nxt.rdy   = 1'b0;
      slot_nxt.tleft = sat_time;
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (ctl.seen_clr) begin
      seen_nxt = 1'b0;
    end else if (ctl.seen_step) begin
      seen_nxt = seen_in;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule
